@@ src/mpsd_pkg.sv @@
// Shared types and constants of the multichannel PWM shift driver.
package mpsd_pkg;

   localparam int CH_W   = 6;
   localparam int DUTY_W = 8;
   localparam int STEP_W = 8;

   localparam logic              REQ_WRITE         = 1'b0;
   localparam logic              REQ_TICK          = 1'b1;
   localparam logic [STEP_W-1:0] FRAME_STEPS_RESET = 8'hFF;

   typedef struct packed {
      logic              req_type;
      logic [CH_W-1:0]   channel;
      logic [DUTY_W-1:0] duty_value;
   } req_item_type;

   typedef struct packed {
      logic            serial_bit;
      logic [CH_W-1:0] bit_channel;
      logic            latch_pulse;
   } rsp_item_type;

endpackage

@@ src/multichannel_pwm_shift_driver.sv @@
// Top level of the multichannel PWM shift driver.
//
// Request items come in on req_*: a duty write stores one channel's 8-bit duty
// and gives no result; a tick sends one bit for every channel, lowest channel
// first, on rsp_*, with latch_pulse set on the last bit. A bit is 1 while the
// frame step is below the channel's duty. csr_* writes frame_steps, the number
// of steps per frame; it is always ready and is to be written only while idle,
// which the block itself does not enforce. Duties live in a RAM with registered
// read, one entry per channel. A tick reads one entry per cycle while rsp_stall
// does not hold the pipeline, and holds off new requests until the last entry
// has been read. Its bits pass through the RAM read and the output register and
// follow one per cycle while rsp_stall is low. A stall on rsp_stall freezes the
// read pipeline and the output register, and so delays the end of the tick.
// Reset clears the per-channel valid bits, so every duty reads as zero, sets the
// step counter to zero and frame_steps to 255. No clearing pass is needed.
// A write to a channel at or above CHANNELS is dropped.
module multichannel_pwm_shift_driver #(
   parameter int CHANNELS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mpsd_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mpsd_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mpsd_pkg::STEP_W-1:0]         csr_data
);

   localparam int ADDR_W = $clog2(CHANNELS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                          state_ff, state_in;
   logic [mpsd_pkg::CH_W-1:0]     issue_ch_ff, issue_ch_in;
   logic [mpsd_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [mpsd_pkg::STEP_W-1:0]   tick_step_ff, tick_step_in;
   logic [mpsd_pkg::STEP_W-1:0]   frame_steps_ff, frame_steps_in;
   logic [CHANNELS-1:0]           vld_ff, vld_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_vld_ff, s1_vld_in;
   logic [mpsd_pkg::CH_W-1:0]     s1_ch_ff, s1_ch_in;
   logic [mpsd_pkg::STEP_W-1:0]   s1_step_ff, s1_step_in;
   logic                          s1_last_ff, s1_last_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   mpsd_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                          req_acc;
   logic                          wr_en;
   logic                          out_free;
   logic                          s1_free;
   logic                          issue;
   logic                          issue_last;
   logic [mpsd_pkg::STEP_W:0]     step_next;
   logic [mpsd_pkg::DUTY_W-1:0]   ram_rd_data;
   logic [mpsd_pkg::DUTY_W-1:0]   s1_duty;

   assign req_stall = (state_ff == ST_RUN);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign wr_en = req_acc && (req_item.req_type == mpsd_pkg::REQ_WRITE) &&
                  ({1'b0, req_item.channel} < (mpsd_pkg::CH_W + 1)'(CHANNELS));

   // The output register frees when empty or taken; the RAM data stage moves on then.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_free    = !s1_valid_ff || out_free;
   assign issue      = (state_ff == ST_RUN) && s1_free;
   assign issue_last = (issue_ch_ff == mpsd_pkg::CH_W'(CHANNELS - 1));

   assign step_next = {1'b0, step_ff} + (mpsd_pkg::STEP_W + 1)'(1);
   assign s1_duty   = s1_vld_ff ? ram_rd_data : '0;

   mpsd_ram #(
      .WIDTH (mpsd_pkg::DUTY_W),
      .DEPTH (CHANNELS)
   ) duty_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_item.channel[ADDR_W-1:0]),
      .wr_data (req_item.duty_value),
      .rd_en   (issue),
      .rd_addr (issue_ch_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      issue_ch_in    = issue_ch_ff;
      step_in        = step_ff;
      tick_step_in   = tick_step_ff;
      frame_steps_in = frame_steps_ff;
      vld_in         = vld_ff;

      if (csr_valid && csr_ready) begin
         frame_steps_in = csr_data;
      end
      if (wr_en) begin
         vld_in[req_item.channel[ADDR_W-1:0]] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_item.req_type == mpsd_pkg::REQ_TICK)) begin
               state_in     = ST_RUN;
               issue_ch_in  = '0;
               tick_step_in = step_ff;
               // Advancing at acceptance gives the same frame as advancing after the bits.
               if (step_next >= {1'b0, frame_steps_ff}) begin
                  step_in = '0;
               end else begin
                  step_in = step_next[mpsd_pkg::STEP_W-1:0];
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               issue_ch_in = issue_ch_ff + mpsd_pkg::CH_W'(1);
               if (issue_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_vld_in   = s1_vld_ff;
      s1_ch_in    = s1_ch_ff;
      s1_step_in  = s1_step_ff;
      s1_last_in  = s1_last_ff;
      if (s1_free) begin
         s1_valid_in = issue;
         s1_vld_in   = vld_ff[issue_ch_ff[ADDR_W-1:0]];
         s1_ch_in    = issue_ch_ff;
         s1_step_in  = tick_step_ff;
         s1_last_in  = issue_last;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_free) begin
         rsp_valid_in            = s1_valid_ff;
         rsp_item_in.serial_bit  = (s1_step_ff < s1_duty);
         rsp_item_in.bit_channel = s1_ch_ff;
         rsp_item_in.latch_pulse = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_ch_ff    <= '0;
         step_ff        <= '0;
         frame_steps_ff <= mpsd_pkg::FRAME_STEPS_RESET;
         vld_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_ch_ff    <= issue_ch_in;
         step_ff        <= step_in;
         frame_steps_ff <= frame_steps_in;
         vld_ff         <= vld_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_step_ff <= tick_step_in;
      s1_vld_ff    <= s1_vld_in;
      s1_ch_ff     <= s1_ch_in;
      s1_step_ff   <= s1_step_in;
      s1_last_ff   <= s1_last_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ src/mpsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mpsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
